FILE: rtl/core/eig_pkg.sv
// ----------------------------------------------------------------------------
// eig_pkg: shared types and constants of the event id generator
// widths of the id fields, register indexes and the base64 character map
// ----------------------------------------------------------------------------
package eig_pkg;

	localparam int TsW      = 36;
	localparam int RndW     = 8;
	localparam int SeqW     = 12;
	localparam int NodeW    = 48;
	localparam int CharW    = 7;
	localparam int SymW     = 6;
	localparam int IdLen    = 24;
	localparam int IdW      = TsW + 2 * NodeW + SeqW;
	localparam int CntW     = $clog2(IdLen);
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = NodeW;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_NODE_UPPER = 1'b0,
		CFG_NODE_LOWER = 1'b1
	} cfg_reg_t;

	// id word handed from the sequence stage to the serializer
	typedef struct packed {
		logic           valid;
		logic           ovf;
		logic [IdW-1:0] word;
	} id_word_t;

	// ordered base64: - 0-9 A-Z _ a-z
	function automatic logic [CharW-1:0] sym_to_ascii(input logic [SymW-1:0] sym);
		logic [CharW-1:0] s;
		s = {1'b0, sym};
		if (sym == 6'd0) begin
			sym_to_ascii = 7'h2D;
		end else if (sym <= 6'd10) begin
			sym_to_ascii = s + 7'h2F;
		end else if (sym <= 6'd36) begin
			sym_to_ascii = s + 7'h36;
		end else if (sym == 6'd37) begin
			sym_to_ascii = 7'h5F;
		end else begin
			sym_to_ascii = s + 7'h3B;
		end
	endfunction

endpackage

FILE: rtl/core/eig_if.sv
// ----------------------------------------------------------------------------
// eig interfaces: request, character and configuration channels
// valid/ready channels with source, sink and monitor views
// ----------------------------------------------------------------------------
interface eig_req_if import eig_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [TsW-1:0]  timestamp;
	logic [RndW-1:0] random_start;

	modport source (output valid, timestamp, random_start, input ready);
	modport sink   (input valid, timestamp, random_start, output ready);
	modport mon    (input valid, ready, timestamp, random_start);
endinterface

interface eig_chr_if import eig_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] id_char;
	logic             last_char;
	logic             seq_overflow;

	modport source (output valid, id_char, last_char, seq_overflow, input ready);
	modport sink   (input valid, id_char, last_char, seq_overflow, output ready);
	modport mon    (input valid, ready, id_char, last_char, seq_overflow);
endinterface

interface eig_cfg_if import eig_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
	modport mon    (input valid, ready, index, data);
endinterface

FILE: rtl/core/eig_seq_ctrl.sv
// ----------------------------------------------------------------------------
// eig_seq_ctrl: node id registers, sequence state and input register
// builds the 144-bit id word for each accepted request
// ----------------------------------------------------------------------------
module eig_seq_ctrl import eig_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	eig_cfg_if.sink      cfg,
	eig_req_if.sink      req,
	input  logic         take,
	output id_word_t     word_s1
);

	logic [NodeW-1:0] node_upper_q;
	logic [NodeW-1:0] node_lower_q;
	logic [TsW-1:0]   prev_ts_q;
	logic [SeqW-1:0]  prev_seq_q;
	logic             valid_s1;
	logic             ovf_s1;
	logic [IdW-1:0]   id_s1;

	logic             accept;
	logic             same_ts;
	logic [SeqW:0]    seq_inc;
	logic             ovf;
	logic [SeqW-1:0]  seq;

	assign cfg.ready = 1'b1;
	assign req.ready = !valid_s1 || take;
	assign accept    = req.valid && req.ready;

	assign same_ts = req.timestamp == prev_ts_q;
	assign seq_inc = {1'b0, prev_seq_q} + {{SeqW{1'b0}}, 1'b1};
	assign ovf     = same_ts && seq_inc[SeqW];

	always_comb begin
		if (!same_ts) begin
			seq = {{(SeqW-RndW){1'b0}}, req.random_start};
		end else if (ovf) begin
			seq = {SeqW{1'b1}};
		end else begin
			seq = seq_inc[SeqW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_upper_q <= '0;
			node_lower_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_NODE_UPPER: node_upper_q <= cfg.data;
				CFG_NODE_LOWER: node_lower_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ts_q  <= '0;
			prev_seq_q <= '0;
		end else if (accept) begin
			if (!same_ts) begin
				prev_ts_q  <= req.timestamp;
				prev_seq_q <= seq;
			end else if (!ovf) begin
				prev_seq_q <= seq;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ovf_s1 <= ovf;
			id_s1  <= {req.timestamp, node_upper_q, node_lower_q, seq};
		end
	end

	assign word_s1 = '{valid: valid_s1, ovf: ovf_s1, word: id_s1};

endmodule

FILE: rtl/core/eig_serializer.sv
// ----------------------------------------------------------------------------
// eig_serializer: id word to character stream
// shifts out six bits a cycle while chr is not stalled, maps them to ascii, output register
// ----------------------------------------------------------------------------
module eig_serializer import eig_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  id_word_t  word_s1,
	output logic      take,
	eig_chr_if.source chr
);

	logic [IdW-1:0]   sh_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             ovf_q;
	logic             o_valid_q;
	logic [CharW-1:0] o_char_q;
	logic             o_last_q;
	logic             o_ovf_q;

	logic             out_adv;
	logic             emit;
	logic             at_last;
	logic             fin;

	assign out_adv = !o_valid_q || chr.ready;
	assign emit    = out_adv && busy_q;
	assign at_last = cnt_q == CntW'(IdLen - 1);
	assign fin     = emit && at_last;
	assign take    = word_s1.valid && (!busy_q || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (emit) begin
			cnt_q <= cnt_q + CntW'(1);
			if (at_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sh_q  <= word_s1.word;
			ovf_q <= word_s1.ovf;
		end else if (emit) begin
			sh_q <= {sh_q[IdW-SymW-1:0], {SymW{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (out_adv) begin
			o_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			o_char_q <= sym_to_ascii(sh_q[IdW-1 -: SymW]);
			o_last_q <= at_last;
			o_ovf_q  <= ovf_q;
		end
	end

	assign chr.valid        = o_valid_q;
	assign chr.id_char      = o_char_q;
	assign chr.last_char    = o_last_q;
	assign chr.seq_overflow = o_ovf_q;

endmodule

FILE: rtl/core/event_id_generator_unit.sv
// ----------------------------------------------------------------------------
// event_id_generator_unit: snowflake style unique event id generator
// one request in, 24 ascii characters out: timestamp, node id, sequence
// ----------------------------------------------------------------------------
//
//  channel  role  payload                                   transfer when
//  -------  ----  ----------------------------------------  ------------------
//  cfg      sink  index (0 node upper, 1 node lower), data  valid && ready
//  req      sink  timestamp[35:0], random_start[7:0]        valid && ready
//  chr      src   id_char[6:0], last_char, seq_overflow     valid && ready
//
//  - the serializer emits one 6-bit character a cycle while chr is not stalled
//  - each character passes the sequence stage, shift and output registers
//  - one request is buffered ahead of the serializer, so the next id is loaded
//    in the same cycle as the last character of the previous one is emitted
//  - arst_n clears node id, sequence state and all valid flags
//  - chr stalls hold the output register and freeze the serializer
//
module event_id_generator_unit import eig_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	eig_cfg_if.sink   cfg,
	eig_req_if.sink   req,
	eig_chr_if.source chr
);

	// id word from the sequence stage and the serializer's load strobe
	id_word_t word_s1;
	logic     take;

	// sequence update happens at the request transfer, so back-to-back
	// requests see the state left by the one before
	eig_seq_ctrl u_seq_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.req     (req),
		.take    (take),
		.word_s1 (word_s1)
	);

	// character stream, most significant character first
	eig_serializer u_serializer (
		.clk     (clk),
		.arst_n  (arst_n),
		.word_s1 (word_s1),
		.take    (take),
		.chr     (chr)
	);

endmodule

FILE: rtl/core/eig_checker.sv
// ----------------------------------------------------------------------------
// eig_checker: port level checks of the event id generator
// character framing, overflow flag and pending id bookkeeping
// ----------------------------------------------------------------------------
module eig_checker import eig_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             chr_valid,
	input logic             chr_ready,
	input logic [CharW-1:0] chr_id_char,
	input logic             chr_last_char,
	input logic             chr_seq_overflow
);

	logic [CntW-1:0] pos_q;
	logic [2:0]      pend_q;
	logic            ovf_q;
	logic            req_xfer;
	logic            chr_xfer;
	logic            id_done;

	assign req_xfer = req_valid && req_ready;
	assign chr_xfer = chr_valid && chr_ready;
	assign id_done  = chr_xfer && chr_last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pend_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (chr_xfer) begin
				pos_q <= (pos_q == CntW'(IdLen - 1)) ? '0 : pos_q + CntW'(1);
				ovf_q <= chr_seq_overflow;
			end
			pend_q <= pend_q + {2'b0, req_xfer} - {2'b0, id_done};
		end
	end

	a_last_framing: assert property (@(posedge clk) disable iff (!arst_n)
		chr_xfer |-> (chr_last_char == (pos_q == CntW'(IdLen - 1))))
		else $error("last_char out of place in the id");

	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		chr_xfer && (pos_q != '0) |-> (chr_seq_overflow == ovf_q))
		else $error("seq_overflow changed within one id");

	a_ovf_zz: assert property (@(posedge clk) disable iff (!arst_n)
		chr_xfer && chr_seq_overflow && (pos_q >= CntW'(IdLen - 2)) |->
		(chr_id_char == 7'h7A))
		else $error("exhausted sequence not sent as zz");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid |-> (pend_q != '0))
		else $error("character shown with no request pending");

	a_chr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && !chr_ready |=> chr_valid && $stable(chr_id_char))
		else $error("stalled character dropped or changed");

endmodule

bind event_id_generator_unit eig_checker u_eig_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.chr_valid        (chr.valid),
	.chr_ready        (chr.ready),
	.chr_id_char      (chr.id_char),
	.chr_last_char    (chr.last_char),
	.chr_seq_overflow (chr.seq_overflow)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for event_id_generator_unit
// sends id requests, predicts all 24 ascii characters of every id, including
// sequence restarts, increments and exhaustion, and checks each character
// transfer under several node id settings and idle/stall mixes
// ----------------------------------------------------------------------------
module testbench;
	import eig_pkg::*;

	typedef struct packed {
		logic [TsW-1:0]  ts;
		logic [RndW-1:0] rnd;
	} id_request_t;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic             last;
		logic             ovf;
	} id_char_t;

	localparam logic [TsW-1:0]   TsMax   = '1;
	localparam logic [NodeW-1:0] NodeMax = '1;
	localparam int               MaxErrorReports = 60;

	// clock and reset, known from time zero
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// driven request, character and configuration signals
	logic            req_valid = 1'b0;
	logic [TsW-1:0]  req_ts    = '0;
	logic [RndW-1:0] req_rnd   = '0;
	logic            chr_ready = 1'b0;
	logic                cfg_valid = 1'b0;
	cfg_reg_t            cfg_index = CFG_NODE_UPPER;
	logic [CfgDataW-1:0] cfg_data  = '0;

	eig_cfg_if cfg_bus ();
	eig_req_if req_bus ();
	eig_chr_if chr_bus ();

	assign cfg_bus.valid        = cfg_valid;
	assign cfg_bus.index        = cfg_index;
	assign cfg_bus.data         = cfg_data;
	assign req_bus.valid        = req_valid;
	assign req_bus.timestamp    = req_ts;
	assign req_bus.random_start = req_rnd;
	assign chr_bus.ready        = chr_ready;

	event_id_generator_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.chr    (chr_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// requests waiting to be driven and characters waiting to come out
	id_request_t pending_requests[$];
	id_char_t    expected_chars[$];

	// idle mix of the current phase, in percent of cycles
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int error_count   = 0;

	// predictor copy of the node id registers and of the sequence state
	logic [NodeW-1:0] node_upper = '0;
	logic [NodeW-1:0] node_lower = '0;
	logic [TsW-1:0]   held_ts    = '0;
	logic [SeqW-1:0]  held_seq   = '0;

	// ordered base64: dash, digits, upper case, underscore, lower case
	string base64_ordered = {"-0123456789", "ABCDEFGHIJKLMNOPQRSTUVWXYZ", "_",
		"abcdefghijklmnopqrstuvwxyz"};

	// update the sequence state for one accepted request and queue its characters
	task automatic predict_id_chars(input id_request_t rq);
		logic [SeqW-1:0] seq;
		logic            ovf;
		logic [IdW-1:0]  word;
		logic [SymW-1:0] sym;
		byte             b;
		id_char_t        c;
		ovf = 1'b0;
		if (rq.ts == held_ts) begin
			// same decisecond: count up unless the sequence is used up
			if (held_seq == '1) begin
				ovf = 1'b1;
				seq = '1;
			end else begin
				held_seq = held_seq + 1'b1;
				seq      = held_seq;
			end
		end else begin
			// new decisecond: restart from the random start value
			held_ts  = rq.ts;
			held_seq = SeqW'(rq.rnd);
			seq      = held_seq;
		end
		word = {rq.ts, node_upper, node_lower, seq};
		for (int i = 0; i < IdLen; i++) begin
			sym    = word[IdW - 1 - SymW * i -: SymW];
			b      = base64_ordered[int'(sym)];
			c.ch   = b[CharW-1:0];
			c.last = (i == IdLen - 1);
			c.ovf  = ovf;
			expected_chars.push_back(c);
		end
	endtask

	task automatic report_field(input string name, input logic [CharW-1:0] want,
		input logic [CharW-1:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= MaxErrorReports)
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endtask

	// request driver: predicts on every transfer, then offers the next item
	always @(posedge clk) begin
		id_request_t rq;
		if (arst_n) begin
			if (req_valid && req_bus.ready)
				predict_id_chars({req_ts, req_rnd});
			if (!req_valid || req_bus.ready) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					rq = pending_requests.pop_front();
					req_valid <= 1'b1;
					req_ts    <= rq.ts;
					req_rnd   <= rq.rnd;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// character monitor: random backpressure and per-field compare
	always @(posedge clk) begin
		id_char_t want;
		if (arst_n) begin
			chr_ready <= ($urandom_range(99) >= stall_pct);
			if (chr_bus.valid && chr_ready) begin
				if (expected_chars.size() == 0) begin
					error_count++;
					if (error_count <= MaxErrorReports)
						$error("unexpected character transfer: id_char 0x%0h",
							chr_bus.id_char);
				end else begin
					want = expected_chars.pop_front();
					report_field("id_char", want.ch, chr_bus.id_char);
					report_field("last_char", CharW'(want.last), CharW'(chr_bus.last_char));
					report_field("seq_overflow", CharW'(want.ovf),
						CharW'(chr_bus.seq_overflow));
				end
			end
		end
	end

	// single register write, waits for the transfer
	task automatic write_node_reg(input cfg_reg_t idx, input logic [NodeW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_bus.ready));
		if (idx == CFG_NODE_UPPER)
			node_upper = val;
		else
			node_lower = val;
		cfg_valid <= 1'b0;
	endtask

	// block is idle once nothing is queued, offered or owed, plus a short tail
	task automatic wait_drained();
		while (pending_requests.size() != 0 || req_valid || expected_chars.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic push_request(input logic [TsW-1:0] ts, input logic [RndW-1:0] rnd);
		pending_requests.push_back({ts, rnd});
	endtask

	// random phase: mostly runs of one timestamp so the sequence counts up,
	// mixed with new, neighboring and extreme timestamps
	task automatic run_random_phase(input logic [NodeW-1:0] upper,
		input logic [NodeW-1:0] lower, input int idle_pct, input int stall,
		input int count);
		logic [TsW-1:0] ts;
		int             pick;
		wait_drained();
		write_node_reg(CFG_NODE_UPPER, upper);
		write_node_reg(CFG_NODE_LOWER, lower);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		ts = held_ts;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 55)
				ts = ts;
			else if (pick < 65)
				ts = $urandom_range(1) ? TsMax : '0;
			else if (pick < 75)
				ts = ts + 1'b1;
			else
				ts = {4'($urandom), $urandom};
			push_request(ts, RndW'($urandom_range(255)));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: reset node id, first request on timestamp zero counts
		// as a repeat, restarts, extremes and bit patterns
		push_request('0, 8'hA5);
		push_request('0, 8'h00);
		push_request('0, 8'hFF);
		push_request(TsMax, 8'hFF);
		push_request(TsMax, 8'h00);
		push_request(TsMax, 8'h00);
		push_request(36'h1, 8'h00);
		push_request(36'h1, 8'h3F);
		push_request('0, 8'h80);
		push_request(36'hAAAAAAAAA, 8'h55);
		push_request(36'h555555555, 8'hAA);
		push_request(36'h800000000, 8'h01);
		push_request(36'hFFFFFFFFE, 8'h7F);
		push_request(36'hFFFFFFFFE, 8'h7F);

		// all-ones node id, one restart and one repeat
		wait_drained();
		write_node_reg(CFG_NODE_UPPER, NodeMax);
		write_node_reg(CFG_NODE_LOWER, NodeMax);
		push_request(36'h12345678A, 8'h00);
		push_request(36'h12345678A, 8'h00);

		run_random_phase({16'($urandom), $urandom}, {16'($urandom), $urandom}, 0, 0, 45);
		run_random_phase(48'h555555555555, 48'hAAAAAAAAAAAA, 45, 0, 45);
		run_random_phase('0, NodeMax, 0, 45, 45);
		run_random_phase({16'($urandom), $urandom}, {16'($urandom), $urandom}, 13, 13, 45);
		wait_drained();

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// hang guard, well beyond the slowest passing run
	initial begin
		#30ms;
		$error("timeout: %0d characters still expected", expected_chars.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/eig_pkg.sv
rtl/core/eig_if.sv
rtl/core/eig_seq_ctrl.sv
rtl/core/eig_serializer.sv
rtl/core/event_id_generator_unit.sv
rtl/core/eig_checker.sv
tb/testbench.sv
